// ----- rtl/core/circle_inlier_scorer_assert.svh -----
// ----------------------------------------------------------------------------
// Circle inlier scorer assertion macros
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_INLIER_SCORER_ASSERT_SVH
`define CIRCLE_INLIER_SCORER_ASSERT_SVH

`ifndef SYNTHESIS
`define CIS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("circle_inlier_scorer check failed");
`define CIS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("circle_inlier_scorer sequence check failed");
`else
`define CIS_ASSERT(lbl, prop)
`define CIS_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- rtl/core/cis_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle inlier scorer package
// Widths, limits, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package cis_pkg;

	localparam int PT_W       = 10;
	localparam int CTR_W      = 12;
	localparam int RAD_W      = 11;
	localparam int TOL_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int DIFF_W     = 13;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int ITER_W     = $clog2(ROOT_W);
	localparam int MAX_POINTS = 4096;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int LOST_W     = 13;
	localparam int ERR_W      = 20;
	localparam int ROW_W      = 16;

	localparam logic [ROW_W-1:0]  ROW_NONE  = '1;
	localparam logic [ERR_W-1:0]  ERR_MAX   = '1;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_W - 1);

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TOL      = CFG_IDX_W'(3);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SQX  = 7'b0000010,
		S_SQY  = 7'b0000100,
		S_ROOT = 7'b0001000,
		S_MAG  = 7'b0010000,
		S_ACC  = 7'b0100000,
		S_VERD = 7'b1000000
	} state_t;

endpackage

// ----- rtl/core/circle_inlier_scorer.sv -----
// ----------------------------------------------------------------------------
// Circle inlier scorer
// Scores edge points against a configured circle and emits one verdict per
// point set, using one shared multiplier and a one-bit-per-cycle square root.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    point_x, point_y, last_point
// out      source     out_valid / out_ready  fit_ok, top_row, lost_total, error_total
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each point passes from the request through squaring of dx and then dy on the
// shared multiplier, 13 square root iterations, deviation and update, and no new
// point is taken before the update. The last point of a set adds a verdict
// state, held while a prior verdict still waits on out_ready. Reset clears
// accumulators and registers (tolerance 4).
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "circle_inlier_scorer_assert.svh"

module circle_inlier_scorer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cis_pkg::PT_W-1:0]        point_x,
	input  logic [cis_pkg::PT_W-1:0]        point_y,
	input  logic                            last_point,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            fit_ok,
	output logic [cis_pkg::ROW_W-1:0]       top_row,
	output logic [cis_pkg::LOST_W-1:0]      lost_total,
	output logic [cis_pkg::ERR_W-1:0]       error_total,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cis_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int PT_W   = cis_pkg::PT_W;
	localparam int CTR_W  = cis_pkg::CTR_W;
	localparam int RAD_W  = cis_pkg::RAD_W;
	localparam int TOL_W  = cis_pkg::TOL_W;
	localparam int DIFF_W = cis_pkg::DIFF_W;
	localparam int SQ_W   = cis_pkg::SQ_W;
	localparam int ROOT_W = cis_pkg::ROOT_W;
	localparam int REM_W  = cis_pkg::REM_W;
	localparam int ITER_W = cis_pkg::ITER_W;
	localparam int CNT_W  = cis_pkg::CNT_W;
	localparam int LOST_W = cis_pkg::LOST_W;
	localparam int ERR_W  = cis_pkg::ERR_W;
	localparam int ROW_W  = cis_pkg::ROW_W;
	localparam int VRD_W  = CNT_W + 4;
	localparam int CMP_W  = ERR_W + CNT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(cis_pkg::MAX_POINTS);

	cis_pkg::state_t state_q;

	logic signed [CTR_W-1:0]  center_x_q;
	logic signed [CTR_W-1:0]  center_y_q;
	logic [RAD_W-1:0]         radius_q;
	logic [TOL_W-1:0]         tol_q;

	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic [PT_W-1:0]          py_q;
	logic                     last_q;
	logic [SQ_W-1:0]          op_q;
	logic [ROOT_W-1:0]        root_q;
	logic [REM_W-1:0]         rem_q;
	logic [ITER_W-1:0]        iter_q;
	logic [ROOT_W-1:0]        mag_q;

	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         lost_q;
	logic [ERR_W-1:0]         err_q;
	logic [ROW_W-1:0]         row_q;

	logic                     out_valid_q;
	logic                     fit_ok_q;
	logic [ROW_W-1:0]         top_row_q;
	logic [LOST_W-1:0]        lost_total_q;
	logic [ERR_W-1:0]         error_total_q;

	logic                     in_req;
	logic signed [DIFF_W-1:0] mult_a;
	logic signed [SQ_W-1:0]   mult_p;
	logic [REM_W+1:0]         rem_sh;
	logic [REM_W+1:0]         trial;
	logic                     take;
	logic [ROOT_W-1:0]        rad_ext;
	logic [ROOT_W-1:0]        root_adj;
	logic                     inlier;
	logic [ERR_W:0]           err_add;
	logic [VRD_W-1:0]         lost10;
	logic [VRD_W-1:0]         cnt7;
	logic                     ok;
	logic                     verd_go;

	assign in_ready  = (state_q == cis_pkg::S_IDLE);
	assign in_req    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// shared squaring unit
	assign mult_a = (state_q == cis_pkg::S_SQX) ? dx_q : dy_q;
	assign mult_p = mult_a * mult_a;

	// one root bit per cycle
	assign rem_sh = {rem_q, op_q[SQ_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	assign rad_ext  = ROOT_W'(radius_q);
	assign root_adj = ((root_q < rad_ext) && (rem_q != '0)) ? root_q + 1'b1 : root_q;

	assign inlier  = (mag_q < ROOT_W'(tol_q));
	assign err_add = {1'b0, err_q} + (ERR_W+1)'(mag_q);

	assign lost10  = (VRD_W'(lost_q) << 3) + (VRD_W'(lost_q) << 1);
	assign cnt7    = (VRD_W'(cnt_q) << 3) - VRD_W'(cnt_q);
	assign ok      = !(lost10 > cnt7) && !(CMP_W'(err_q) > CMP_W'(cnt_q));
	assign verd_go = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
			tol_q      <= TOL_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cis_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				cis_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				cis_pkg::REG_RADIUS:   radius_q   <= cfg_data[RAD_W-1:0];
				cis_pkg::REG_TOL:      tol_q      <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cis_pkg::S_IDLE;
			iter_q      <= '0;
			cnt_q       <= '0;
			lost_q      <= '0;
			err_q       <= '0;
			row_q       <= cis_pkg::ROW_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				cis_pkg::S_IDLE: begin
					if (in_req) begin
						state_q <= cis_pkg::S_SQX;
					end
				end
				cis_pkg::S_SQX: begin
					state_q <= cis_pkg::S_SQY;
				end
				cis_pkg::S_SQY: begin
					iter_q  <= '0;
					state_q <= cis_pkg::S_ROOT;
				end
				cis_pkg::S_ROOT: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == cis_pkg::ITER_LAST) begin
						state_q <= cis_pkg::S_MAG;
					end
				end
				cis_pkg::S_MAG: begin
					state_q <= cis_pkg::S_ACC;
				end
				cis_pkg::S_ACC: begin
					if (inlier) begin
						err_q <= err_add[ERR_W] ? cis_pkg::ERR_MAX : err_add[ERR_W-1:0];
						if (ROW_W'(py_q) < row_q) begin
							row_q <= ROW_W'(py_q);
						end
					end else if (lost_q < CNT_MAX) begin
						lost_q <= lost_q + 1'b1;
					end
					if (cnt_q < CNT_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= last_q ? cis_pkg::S_VERD : cis_pkg::S_IDLE;
				end
				cis_pkg::S_VERD: begin
					if (verd_go) begin
						out_valid_q <= 1'b1;
						cnt_q       <= '0;
						lost_q      <= '0;
						err_q       <= '0;
						row_q       <= cis_pkg::ROW_NONE;
						state_q     <= cis_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= cis_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_req) begin
			dx_q   <= $signed({{(DIFF_W-PT_W){1'b0}}, point_x})
				- $signed({{(DIFF_W-CTR_W){center_x_q[CTR_W-1]}}, center_x_q});
			dy_q   <= $signed({{(DIFF_W-PT_W){1'b0}}, point_y})
				- $signed({{(DIFF_W-CTR_W){center_y_q[CTR_W-1]}}, center_y_q});
			py_q   <= point_y;
			last_q <= last_point;
		end
		if (state_q == cis_pkg::S_SQX) begin
			op_q <= $unsigned(mult_p);
		end else if (state_q == cis_pkg::S_SQY) begin
			op_q   <= op_q + $unsigned(mult_p);
			root_q <= '0;
			rem_q  <= '0;
		end else if (state_q == cis_pkg::S_ROOT) begin
			op_q   <= op_q << 2;
			root_q <= {root_q[ROOT_W-2:0], take};
			rem_q  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
		end
		if (state_q == cis_pkg::S_MAG) begin
			mag_q <= (root_adj >= rad_ext) ? root_adj - rad_ext : rad_ext - root_adj;
		end
		if ((state_q == cis_pkg::S_VERD) && verd_go) begin
			fit_ok_q      <= ok;
			top_row_q     <= ok ? row_q : cis_pkg::ROW_NONE;
			lost_total_q  <= LOST_W'(lost_q);
			error_total_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign fit_ok      = fit_ok_q;
	assign top_row     = top_row_q;
	assign lost_total  = lost_total_q;
	assign error_total = error_total_q;

	`CIS_ASSERT(a_lost_le_cnt, (lost_q <= cnt_q) && (cnt_q <= CNT_MAX))
	`CIS_ASSERT_NEXT(a_root_done, (state_q == cis_pkg::S_ROOT) && (iter_q == cis_pkg::ITER_LAST), state_q == cis_pkg::S_MAG)
	`CIS_ASSERT(a_ok_has_row, (out_valid_q && fit_ok_q) |-> (top_row_q != cis_pkg::ROW_NONE))

endmodule

// ----- sim/circle_inlier_scorer_test.sv -----
// ----------------------------------------------------------------------------
// Circle inlier scorer testbench
// Drives point sets through the scorer under several circle settings and
// checks every verdict against a cycle-free model of the scoring rules. A
// short directed part covers the register extremes, the root rounding cases
// and both rejection rules; random sets follow. Requests come in bursts with
// random gaps, and the verdict side stalls on a changing ready pattern.
// ----------------------------------------------------------------------------
module circle_inlier_scorer_test;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 25;
	localparam int RANDOM_POINTS = 360;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [cis_pkg::PT_W-1:0]       point_x;
	logic [cis_pkg::PT_W-1:0]       point_y;
	logic                           last_point;
	logic                           out_valid;
	logic                           out_ready;
	logic                           fit_ok;
	logic [cis_pkg::ROW_W-1:0]      top_row;
	logic [cis_pkg::LOST_W-1:0]     lost_total;
	logic [cis_pkg::ERR_W-1:0]      error_total;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [cis_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cis_pkg::CFG_DATA_W-1:0] cfg_data;

	typedef struct {
		logic                       fit_ok;
		logic [cis_pkg::ROW_W-1:0]  top_row;
		logic [cis_pkg::LOST_W-1:0] lost_total;
		logic [cis_pkg::ERR_W-1:0]  error_total;
	} verdict_t;

	class verdict_board;
		int          cx;
		int          cy;
		int unsigned radius;
		int unsigned tol;
		int unsigned count;
		int unsigned lost;
		int unsigned err;
		int unsigned min_row;
		verdict_t    pending_verdicts[$];
		int          points;
		int          verdicts;
		int          mismatches;

		function new();
			cx = 0;
			cy = 0;
			radius = 0;
			tol = 4;
			points = 0;
			verdicts = 0;
			mismatches = 0;
			clear_set();
		endfunction

		function void clear_set();
			count = 0;
			lost = 0;
			err = 0;
			min_row = cis_pkg::ROW_NONE;
		endfunction

		function int unsigned floor_root(int unsigned v);
			int unsigned r;
			longint unsigned t;
			r = 0;
			for (int b = 15; b >= 0; b--) begin
				t = r | (1 << b);
				if (t * t <= v)
					r = t;
			end
			return r;
		endfunction

		function void load_reg(logic [cis_pkg::CFG_IDX_W-1:0] idx,
		                       logic [cis_pkg::CFG_DATA_W-1:0] data);
			case (idx)
			cis_pkg::REG_CENTER_X: cx = int'($signed(data));
			cis_pkg::REG_CENTER_Y: cy = int'($signed(data));
			cis_pkg::REG_RADIUS:   radius = data[cis_pkg::RAD_W-1:0];
			cis_pkg::REG_TOL:      tol = data[cis_pkg::TOL_W-1:0];
			default: ;
			endcase
		endfunction

		function void note_point(logic [cis_pkg::PT_W-1:0] x, logic [cis_pkg::PT_W-1:0] y,
		                         logic last);
			int          dx;
			int          dy;
			int unsigned d2;
			int unsigned root;
			int unsigned mag;
			logic        ok;
			verdict_t    v;
			dx = int'(x) - cx;
			dy = int'(y) - cy;
			d2 = dx * dx + dy * dy;
			root = floor_root(d2);
			// round the root up when the point sits inside the circle
			if (root < radius && root * root != d2)
				root++;
			mag = (root >= radius) ? root - radius : radius - root;
			if (mag < tol) begin
				err = (err + mag > cis_pkg::ERR_MAX) ? cis_pkg::ERR_MAX : err + mag;
				if (y < min_row)
					min_row = y;
			end else if (lost < cis_pkg::MAX_POINTS) begin
				lost++;
			end
			if (count < cis_pkg::MAX_POINTS)
				count++;
			points++;
			if (!last)
				return;
			ok = !(lost * 10 > count * 7) && !(err > count);
			v.fit_ok = ok;
			v.top_row = ok ? cis_pkg::ROW_W'(min_row) : cis_pkg::ROW_NONE;
			v.lost_total = cis_pkg::LOST_W'(lost);
			v.error_total = cis_pkg::ERR_W'(err);
			pending_verdicts.push_back(v);
			clear_set();
		endfunction

		function void check_verdict(logic ok, logic [cis_pkg::ROW_W-1:0] row,
		                            logic [cis_pkg::LOST_W-1:0] lost_in,
		                            logic [cis_pkg::ERR_W-1:0] err_in);
			verdict_t want;
			verdicts++;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("verdict %0d with no set pending: ok=%0d row=%0d lost=%0d err=%0d",
					         verdicts, ok, row, lost_in, err_in);
				return;
			end
			want = pending_verdicts.pop_front();
			if (want.fit_ok !== ok || want.top_row !== row ||
			    want.lost_total !== lost_in || want.error_total !== err_in) begin
				mismatches++;
				if (mismatches <= 10)
					$display("verdict %0d: expected ok=%0d row=%0d lost=%0d err=%0d, got ok=%0d row=%0d lost=%0d err=%0d",
					         verdicts, want.fit_ok, want.top_row, want.lost_total,
					         want.error_total, ok, row, lost_in, err_in);
			end
		endfunction
	endclass

	verdict_board sb = new();

	int          burst_left;
	int          reg_writes;
	int          idle_cycles;
	int unsigned rx_cycle;
	logic [15:0] ready_pattern;

	circle_inlier_scorer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.fit_ok     (fit_ok),
		.top_row    (top_row),
		.lost_total (lost_total),
		.error_total(error_total),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_verdict(fit_ok, top_row, lost_total, error_total);
		if (rx_cycle[5:0] == 0) begin
			case ($urandom_range(0, 4))
			0, 1: ready_pattern = '1;
			2, 3: ready_pattern = 16'($urandom) | 16'h1;
			default: ready_pattern = 16'h1 << $urandom_range(0, 15);
			endcase
		end
		out_ready <= ready_pattern[rx_cycle[3:0]];
		rx_cycle++;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Stalled for %0d cycles with %0d verdicts pending",
				         idle_cycles, sb.pending_verdicts.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_point(input logic [cis_pkg::PT_W-1:0] x,
	                          input logic [cis_pkg::PT_W-1:0] y, input logic last);
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		last_point <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_point(x, y, last);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                          : $urandom_range(0, 6);
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_reg(input logic [cis_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [cis_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.load_reg(idx, data);
		reg_writes++;
	endtask

	task automatic program_circle(input logic [cis_pkg::CFG_DATA_W-1:0] cx_data,
	                              input logic [cis_pkg::CFG_DATA_W-1:0] cy_data,
	                              input logic [cis_pkg::CFG_DATA_W-1:0] radius_data,
	                              input logic [cis_pkg::CFG_DATA_W-1:0] tol_data);
		write_reg(cis_pkg::REG_CENTER_X, cx_data);
		write_reg(cis_pkg::REG_CENTER_Y, cy_data);
		write_reg(cis_pkg::REG_RADIUS, radius_data);
		write_reg(cis_pkg::REG_TOL, tol_data);
		// unmapped index, must leave the circle alone
		if ($urandom_range(0, 1))
			write_reg(cis_pkg::CFG_IDX_W'($urandom_range(cis_pkg::REG_TOL + 1,
			                                             (1 << cis_pkg::CFG_IDX_W) - 1)),
			          cis_pkg::CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic pick_point(input int noise, output logic [cis_pkg::PT_W-1:0] x,
	                          output logic [cis_pkg::PT_W-1:0] y);
		int r;
		int ddx;
		int ddy;
		int px;
		int py;
		r = int'(sb.radius);
		ddx = int'($urandom_range(0, 2 * r)) - r;
		ddy = int'(sb.floor_root(r * r - ddx * ddx));
		if ($urandom_range(0, 1))
			ddy = -ddy;
		px = sb.cx + ddx + int'($urandom_range(0, 2 * noise)) - noise;
		py = sb.cy + ddy + int'($urandom_range(0, 2 * noise)) - noise;
		if (px < 0 || px > 1023 || py < 0 || py > 1023 || $urandom_range(0, 4) == 0) begin
			px = $urandom_range(0, 1023);
			py = $urandom_range(0, 1023);
		end
		x = px;
		y = py;
	endtask

	task automatic send_random_set();
		int                       len;
		int                       noise;
		logic [cis_pkg::PT_W-1:0] x;
		logic [cis_pkg::PT_W-1:0] y;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
		noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sb.tol + 2)
		                                     : $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			pick_point(noise, x, y);
			send_point(x, y, i == len - 1);
		end
	endtask

	function automatic logic [cis_pkg::CFG_DATA_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
		0: return cis_pkg::CFG_DATA_W'(-2048);
		1: return cis_pkg::CFG_DATA_W'(2047);
		2, 3: return cis_pkg::CFG_DATA_W'($urandom);
		default: return cis_pkg::CFG_DATA_W'($urandom_range(0, 1023));
		endcase
	endfunction

	initial begin
		int                             start_points;
		logic [cis_pkg::CFG_DATA_W-1:0] rad;
		logic [cis_pkg::CFG_DATA_W-1:0] tol;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		last_point <= 1'b0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		burst_left = 0;
		reg_writes = 0;
		idle_cycles = 0;
		rx_cycle = 0;
		ready_pattern = '1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset circle: origin, zero radius, tolerance four
		send_point(0, 0, 1'b0);
		send_point(3, 0, 1'b0);
		send_point(1023, 1023, 1'b0);
		send_point(4, 0, 1'b1);
		send_point(2, 2, 1'b1);
		settle();

		program_circle(cis_pkg::CFG_DATA_W'(-2048), cis_pkg::CFG_DATA_W'(2047), '1, '1);
		send_point(0, 1023, 1'b0);
		send_point(1023, 0, 1'b0);
		send_point(512, 512, 1'b1);
		settle();

		program_circle(cis_pkg::CFG_DATA_W'(2047), cis_pkg::CFG_DATA_W'(-2048), '0, 12'hF00);
		send_point(1023, 1023, 1'b0);
		send_point(0, 0, 1'b1);
		settle();

		// exact root, rounded-up root, exact root inside the circle
		program_circle(100, 100, 10, 3);
		send_point(106, 108, 1'b0);
		send_point(108, 104, 1'b0);
		send_point(109, 100, 1'b0);
		send_point(108, 105, 1'b0);
		send_point(100, 0, 1'b1);

		start_points = sb.points;
		while (sb.points - start_points < RANDOM_POINTS) begin
			settle();
			case ($urandom_range(0, 9))
			0: rad = '0;
			1: rad = '1;
			2: rad = cis_pkg::CFG_DATA_W'($urandom);
			default: rad = {1'($urandom), 11'($urandom_range(1, 400))};
			endcase
			case ($urandom_range(0, 9))
			0: tol = {4'($urandom), 8'd0};
			1: tol = {4'($urandom), 8'd255};
			2: tol = cis_pkg::CFG_DATA_W'($urandom);
			default: tol = {4'($urandom), 8'($urandom_range(1, 8))};
			endcase
			program_circle(pick_coord(), pick_coord(), rad, tol);
			repeat ($urandom_range(3, 8)) send_random_set();
		end

		settle();
		$display("Scored %0d points in %0d verdicts after %0d register writes,",
		         sb.points, sb.verdicts, reg_writes);
		$display("with register extremes, root rounding and both rejection rules; %0d bad verdicts",
		         sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
